[hdl/cdo_pkg.sv]
// Shared types, constants and calendar functions for the date offset unit.
// No dependencies; used by cdo_ctrl, cdo_datapath and the top level.
package cdo_pkg;

   localparam int DATE_W   = 23;
   localparam int DOFF_W   = 16;
   localparam int MOFF_W   = 13;
   localparam int YOFF_W   = 13;
   localparam int YEAR_W   = 16;   // signed working year
   localparam int MONTH_W  = 14;   // signed working month before wrap
   localparam int DAY_W    = 17;   // signed working day

   localparam logic signed [YEAR_W-1:0]  YEAR_BIAS    = 16'sd4096;
   localparam logic signed [YEAR_W-1:0]  CYCLE_YEARS  = 16'sd400;
   localparam logic signed [YEAR_W-1:0]  COARSE_YEARS = 16'sd3200;
   localparam logic signed [MONTH_W-1:0] MONTHS       = 14'sd12;
   localparam logic signed [MONTH_W-1:0] COARSE_MONTHS = 14'sd96;

   typedef struct packed {
      logic load;
      logic reduce_step;
      logic wrap_step;
      logic walk_step;
      logic capture;
   } cmd_type;

   typedef struct packed {
      logic bypass;
      logic reduce_done;
      logic wrap_done;
      logic walk_done;
   } stat_type;

   // leap test on the year taken modulo 400 (0..399)
   function automatic logic is_leap(input logic [8:0] ym);
      is_leap = (ym[1:0] == 2'd0) && (ym != 9'd100) && (ym != 9'd200) && (ym != 9'd300);
   endfunction

   function automatic logic [4:0] days_of(input logic [3:0] month, input logic leap);
      logic [4:0] n;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
         4'd2:                                       n = leap ? 5'd29 : 5'd28;
         default:                                    n = 5'd0;
      endcase
      days_of = n;
   endfunction

endpackage

[hdl/cdo_ctrl.sv]
// Sequencer for the date offset unit: reduce year mod 400, wrap month,
// walk day month by month, then capture; with all offsets zero it captures at once. Depends on cdo_pkg.
module cdo_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  cdo_pkg::stat_type stat,
   output cdo_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              rsp_strobe
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_WRAP,
      ST_WALK
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (stat.bypass) begin
               cmd.capture = 1'b1;
               strobe_in   = 1'b1;
               state_in    = ST_IDLE;
            end else if (stat.reduce_done) begin
               state_in = ST_WRAP;
            end else begin
               cmd.reduce_step = 1'b1;
            end
         end
         ST_WRAP: begin
            if (stat.wrap_done) state_in = ST_WALK;
            else cmd.wrap_step = 1'b1;
         end
         ST_WALK: begin
            if (stat.walk_done) begin
               cmd.capture = 1'b1;
               strobe_in   = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

[hdl/cdo_datapath.sv]
// Working registers for year, year mod 400, month and day, with the
// per-cycle reduce, wrap and walk steps. Depends on cdo_pkg.
module cdo_datapath (
   input  logic                          clock,
   input  cdo_pkg::cmd_type              cmd,
   input  logic [cdo_pkg::DATE_W-1:0]    req_packed_date,
   input  logic [cdo_pkg::DOFF_W-1:0]    req_day_offset,
   input  logic [cdo_pkg::MOFF_W-1:0]    req_month_offset,
   input  logic [cdo_pkg::YOFF_W-1:0]    req_year_offset,
   output cdo_pkg::stat_type             stat,
   output logic [cdo_pkg::DATE_W-1:0]    rsp_result_date,
   output logic                          rsp_year_overflow
);

   logic signed [cdo_pkg::YEAR_W-1:0]  year_ff, year_in;
   logic signed [cdo_pkg::YEAR_W-1:0]  ymod_ff, ymod_in;   // year mod 400 once reduced
   logic signed [cdo_pkg::MONTH_W-1:0] month_ff, month_in;
   logic signed [cdo_pkg::DAY_W-1:0]   day_ff, day_in;
   logic [cdo_pkg::DATE_W-1:0]         raw_ff;
   logic                               bypass_ff;
   logic [cdo_pkg::DATE_W-1:0]         result_ff, result_in;
   logic                               ovf_ff, ovf_in;

   logic signed [cdo_pkg::YEAR_W-1:0]  year_load;
   logic [8:0]                         ym, ym_inc, ym_dec, ym_inc8, ym_dec8;
   logic [3:0]                         mon4, prev_mon;
   logic [4:0]                         len_cur, len_prev;
   logic signed [cdo_pkg::YEAR_W-1:0]  biased;

   assign year_load = $signed({2'b00, req_packed_date[22:9]}) - cdo_pkg::YEAR_BIAS
                      + $signed({{3{req_year_offset[12]}}, req_year_offset});

   assign ym      = ymod_ff[8:0];
   assign ym_inc  = (ym == 9'd399) ? 9'd0 : ym + 9'd1;
   assign ym_dec  = (ym == 9'd0) ? 9'd399 : ym - 9'd1;
   assign ym_inc8 = (ym >= 9'd392) ? ym - 9'd392 : ym + 9'd8;
   assign ym_dec8 = (ym < 9'd8) ? ym + 9'd392 : ym - 9'd8;

   assign mon4     = month_ff[3:0];
   assign prev_mon = (mon4 == 4'd1) ? 4'd12 : mon4 - 4'd1;
   assign len_cur  = cdo_pkg::days_of(mon4, cdo_pkg::is_leap(ym));
   assign len_prev = cdo_pkg::days_of(prev_mon,
                        cdo_pkg::is_leap((mon4 == 4'd1) ? ym_dec : ym));

   assign stat.bypass      = bypass_ff;
   assign stat.reduce_done = (ymod_ff >= 0) && (ymod_ff < cdo_pkg::CYCLE_YEARS);
   assign stat.wrap_done   = (month_ff >= 1) && (month_ff <= cdo_pkg::MONTHS);
   assign stat.walk_done   = (day_ff >= 1) && (day_ff <= $signed({12'd0, len_cur}));

   assign biased = year_ff + cdo_pkg::YEAR_BIAS;

   always_comb begin
      year_in   = year_ff;
      ymod_in   = ymod_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      result_in = result_ff;
      ovf_in    = ovf_ff;
      if (cmd.load) begin
         year_in  = year_load;
         ymod_in  = year_load;
         month_in = $signed({10'd0, req_packed_date[8:5]})
                    + $signed({req_month_offset[12], req_month_offset});
         day_in   = $signed({12'd0, req_packed_date[4:0]})
                    + $signed({req_day_offset[15], req_day_offset});
      end
      if (cmd.reduce_step) begin
         if (ymod_ff >= cdo_pkg::COARSE_YEARS)      ymod_in = ymod_ff - cdo_pkg::COARSE_YEARS;
         else if (ymod_ff >= cdo_pkg::CYCLE_YEARS)  ymod_in = ymod_ff - cdo_pkg::CYCLE_YEARS;
         else if (ymod_ff < -cdo_pkg::COARSE_YEARS) ymod_in = ymod_ff + cdo_pkg::COARSE_YEARS;
         else                                       ymod_in = ymod_ff + cdo_pkg::CYCLE_YEARS;
      end
      if (cmd.wrap_step) begin
         // eight years at a time while far out of range
         if (month_ff > cdo_pkg::COARSE_MONTHS + cdo_pkg::MONTHS) begin
            month_in = month_ff - cdo_pkg::COARSE_MONTHS;
            year_in  = year_ff + 16'sd8;
            ymod_in  = $signed({7'd0, ym_inc8});
         end else if (month_ff > cdo_pkg::MONTHS) begin
            month_in = month_ff - cdo_pkg::MONTHS;
            year_in  = year_ff + 16'sd1;
            ymod_in  = $signed({7'd0, ym_inc});
         end else if (month_ff < -cdo_pkg::COARSE_MONTHS) begin
            month_in = month_ff + cdo_pkg::COARSE_MONTHS;
            year_in  = year_ff - 16'sd8;
            ymod_in  = $signed({7'd0, ym_dec8});
         end else begin
            month_in = month_ff + cdo_pkg::MONTHS;
            year_in  = year_ff - 16'sd1;
            ymod_in  = $signed({7'd0, ym_dec});
         end
      end
      if (cmd.walk_step) begin
         if (day_ff > $signed({12'd0, len_cur})) begin
            day_in = day_ff - $signed({12'd0, len_cur});
            if (mon4 == 4'd12) begin
               month_in = 14'sd1;
               year_in  = year_ff + 16'sd1;
               ymod_in  = $signed({7'd0, ym_inc});
            end else begin
               month_in = month_ff + 14'sd1;
            end
         end else begin
            // day below one: borrow the previous month's length
            day_in   = day_ff + $signed({12'd0, len_prev});
            month_in = $signed({10'd0, prev_mon});
            if (mon4 == 4'd1) begin
               year_in = year_ff - 16'sd1;
               ymod_in = $signed({7'd0, ym_dec});
            end
         end
      end
      if (cmd.capture) begin
         if (bypass_ff) begin
            result_in = raw_ff;
            ovf_in    = 1'b0;
         end else begin
            result_in = {biased[13:0], mon4, day_ff[4:0]};
            ovf_in    = (biased[15:14] != 2'b00);
         end
      end
   end

   always_ff @(posedge clock) begin
      year_ff   <= year_in;
      ymod_ff   <= ymod_in;
      month_ff  <= month_in;
      day_ff    <= day_in;
      result_ff <= result_in;
      ovf_ff    <= ovf_in;
      if (cmd.load) begin
         raw_ff    <= req_packed_date;
         bypass_ff <= (req_day_offset == '0) && (req_month_offset == '0)
                      && (req_year_offset == '0);
      end
   end

   assign rsp_result_date   = result_ff;
   assign rsp_year_overflow = ovf_ff;

endmodule

[hdl/calendar_date_offset_unit.sv]
// Date offset unit: adds signed day, month and year offsets to a packed date.
// With all offsets zero the input date is returned unchanged; otherwise the
// year is reduced mod 400, the month is wrapped and the day is walked one
// month per step before capture. One word at a time.
// Synchronous active-high reset returns the sequencer to idle; results are
// strobed for one cycle and cannot be held off. Depends on cdo_pkg.
module calendar_date_offset_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [cdo_pkg::DATE_W-1:0]    req_packed_date,
   input  logic [cdo_pkg::DOFF_W-1:0]    req_day_offset,
   input  logic [cdo_pkg::MOFF_W-1:0]    req_month_offset,
   input  logic [cdo_pkg::YOFF_W-1:0]    req_year_offset,
   output logic                          rsp_strobe,
   output logic [cdo_pkg::DATE_W-1:0]    rsp_result_date,
   output logic                          rsp_year_overflow
);

   cdo_pkg::cmd_type  cmd;
   cdo_pkg::stat_type stat;

   cdo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   cdo_datapath u_dp (
      .clock             (clock),
      .cmd               (cmd),
      .req_packed_date   (req_packed_date),
      .req_day_offset    (req_day_offset),
      .req_month_offset  (req_month_offset),
      .req_year_offset   (req_year_offset),
      .stat              (stat),
      .rsp_result_date   (rsp_result_date),
      .rsp_year_overflow (rsp_year_overflow)
   );

`ifndef SYNTHESIS
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result word strobed while still busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not make the unit busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result word strobed on consecutive cycles");

   a_capture_once: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (!cmd.walk_step && !cmd.wrap_step && !cmd.reduce_step))
      else $error("capture issued alongside a working step");
`endif

endmodule
